// File: design/ssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_pkg: shared types and constants for the sorted store span block
// Widths, chain length and the link carried between neighboring cells.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int NUM_CELLS  = 256;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = $clog2(NUM_CELLS + 1);
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = NUM_CELLS / GROUP_SIZE;

  // what one cell shows its right-hand neighbor
  typedef struct packed {
    logic               present;
    logic               gt;
    logic [VALUE_W-1:0] val;
  } link_t;

endpackage

// File: design/ssg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_cell: one slot of the sorted insertion chain
// Holds one value, shifts right when a smaller value is inserted to its left,
// and forms the local gap candidate when the new value lands here.
// ----------------------------------------------------------------------------
module ssg_cell (
  input  logic                               clk,
  input  logic                               load,
  input  logic signed [ssg_pkg::VALUE_W-1:0] new_val,
  input  logic                               occupied,
  input  logic                               tail,
  input  ssg_pkg::link_t                     left,
  output ssg_pkg::link_t                     link,
  output logic [ssg_pkg::VALUE_W-1:0]        gap
);

  logic [ssg_pkg::VALUE_W-1:0] val;
  logic                        gt;
  logic                        ins;
  logic [ssg_pkg::VALUE_W-1:0] d_left;
  logic [ssg_pkg::VALUE_W-1:0] d_right;
  logic [ssg_pkg::VALUE_W-1:0] cand;

  always_comb begin
    gt      = occupied && ($signed(val) > new_val);
    // first slot above the new value, or the first free slot
    ins     = !left.gt && (gt || tail);
    d_left  = left.present ? (ssg_pkg::VALUE_W'(new_val) - left.val) : '1;
    d_right = gt ? (val - ssg_pkg::VALUE_W'(new_val)) : '1;
    cand    = (d_left < d_right) ? d_left : d_right;
    link    = '{present: occupied, gt: gt, val: val};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (left.gt) begin
        val <= left.val;
      end else if (ins) begin
        val <= ssg_pkg::VALUE_W'(new_val);
      end
    end
    gap <= (load && ins) ? cand : '1;
  end

endmodule

// File: design/ssg_gap_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_gap_tree: collects the gap candidate from the cell chain
// Only the inserting cell holds a real candidate, the rest hold all ones, so
// a registered two-level and tree yields the minimum.
// ----------------------------------------------------------------------------
module ssg_gap_tree (
  input  logic                        clk,
  input  logic [ssg_pkg::VALUE_W-1:0] cand [ssg_pkg::NUM_CELLS],
  output logic [ssg_pkg::VALUE_W-1:0] gap_min
);

  logic [ssg_pkg::VALUE_W-1:0] group_and [ssg_pkg::NUM_GROUPS];

  for (genvar g = 0; g < ssg_pkg::NUM_GROUPS; g++) begin : g_group
    logic [ssg_pkg::VALUE_W-1:0] acc;
    always_comb begin
      acc = '1;
      for (int k = 0; k < ssg_pkg::GROUP_SIZE; k++) begin
        acc = acc & cand[g * ssg_pkg::GROUP_SIZE + k];
      end
    end
    always_ff @(posedge clk) begin
      group_and[g] <= acc;
    end
  end

  always_comb begin
    gap_min = '1;
    for (int g = 0; g < ssg_pkg::NUM_GROUPS; g++) begin
      gap_min = gap_min & group_and[g];
    end
  end

endmodule

// File: design/sorted_store_min_max_gap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_store_min_max_gap: bounded sorted set with shortest and longest span
//
// Usage: drive value and pulse start while busy is low; the request is taken
// at that edge. A number is inserted in signed ascending order into a chain
// of 256 cells unless the stored count has reached the capacity, in which
// case status reports full and the set is unchanged.
// Each request gives exactly one result: done is high for one cycle with
// status, stored_count, spans_valid, shortest_span and longest_span. Spans
// read zero while fewer than two numbers are held.
// busy is high from the accepting edge until done, so a new request is taken
// only once the last has its result. A request passes the cell update
// registers and the registered group level of the two-level tree that gathers
// the new neighbor gap, then the result registers. The receiver cannot stall:
// done marks each result once and is not held. Capacity is written through
// cfg_wr_en / cfg_wr_data; the user must do so only while idle, as the block
// does not enforce it. Values above 256 act as 256. Reset (rst, synchronous)
// empties the set and sets the capacity to 256 and smallest_gap to all ones.
// ----------------------------------------------------------------------------
module sorted_store_min_max_gap (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ssg_pkg::VALUE_W-1:0] value,
  input  logic                               cfg_wr_en,
  input  logic [ssg_pkg::COUNT_W-1:0]        cfg_wr_data,
  output logic                               done,
  output logic                               status,
  output logic [ssg_pkg::COUNT_W-1:0]        stored_count,
  output logic                               spans_valid,
  output logic [ssg_pkg::VALUE_W-1:0]        shortest_span,
  output logic [ssg_pkg::VALUE_W-1:0]        longest_span
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GATHER = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                        state;
  logic [ssg_pkg::COUNT_W-1:0]       capacity;
  logic [ssg_pkg::COUNT_W-1:0]       count;
  logic [ssg_pkg::COUNT_W-1:0]       limit;
  logic [ssg_pkg::VALUE_W-1:0]       smallest_gap;
  logic signed [ssg_pkg::VALUE_W-1:0] min_val;
  logic signed [ssg_pkg::VALUE_W-1:0] max_val;
  logic                              full;
  logic                              full_r;
  logic                              accept;
  logic                              load;
  logic [ssg_pkg::VALUE_W-1:0]       gap_min;
  logic [ssg_pkg::VALUE_W-1:0]       gap_next;
  logic                              two_held;

  ssg_pkg::link_t              links [ssg_pkg::NUM_CELLS + 1];
  logic [ssg_pkg::VALUE_W-1:0] cand  [ssg_pkg::NUM_CELLS];

  always_comb begin
    limit    = (capacity > ssg_pkg::COUNT_W'(ssg_pkg::NUM_CELLS)) ?
               ssg_pkg::COUNT_W'(ssg_pkg::NUM_CELLS) : capacity;
    full     = count >= limit;
    busy     = state != ST_IDLE;
    accept   = start && !busy;
    load     = accept && !full;
    two_held = count >= ssg_pkg::COUNT_W'(2);
    gap_next = (gap_min < smallest_gap) ? gap_min : smallest_gap;
  end

  assign links[0] = '0;

  for (genvar i = 0; i < ssg_pkg::NUM_CELLS; i++) begin : g_cell
    ssg_cell u_cell (
      .clk      (clk),
      .load     (load),
      .new_val  (value),
      .occupied (ssg_pkg::COUNT_W'(i) < count),
      .tail     (ssg_pkg::COUNT_W'(i) == count),
      .left     (links[i]),
      .link     (links[i+1]),
      .gap      (cand[i])
    );
  end

  ssg_gap_tree u_gap_tree (
    .clk     (clk),
    .cand    (cand),
    .gap_min (gap_min)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      capacity     <= ssg_pkg::COUNT_W'(ssg_pkg::NUM_CELLS);
      count        <= '0;
      smallest_gap <= '1;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_GATHER;
          end
        end
        ST_GATHER: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          state        <= ST_IDLE;
          smallest_gap <= gap_next;
          done         <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (load) begin
        count <= count + ssg_pkg::COUNT_W'(1);
      end
    end
  end

  // payload: extremes and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      full_r <= full;
    end
    if (load) begin
      if (count == '0) begin
        min_val <= value;
        max_val <= value;
      end else begin
        if (value < min_val) begin
          min_val <= value;
        end
        if (value > max_val) begin
          max_val <= value;
        end
      end
    end
    if (state == ST_FINISH) begin
      status        <= full_r;
      stored_count  <= count;
      spans_valid   <= two_held;
      shortest_span <= two_held ? gap_next : '0;
      longest_span  <= two_held ? (ssg_pkg::VALUE_W'(max_val) - ssg_pkg::VALUE_W'(min_val)) : '0;
    end
  end

endmodule

// File: design/ssg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_checker: port-level checks for the sorted store span block
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module ssg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        status,
  input logic [ssg_pkg::COUNT_W-1:0] stored_count,
  input logic                        spans_valid,
  input logic [ssg_pkg::VALUE_W-1:0] shortest_span,
  input logic [ssg_pkg::VALUE_W-1:0] longest_span
);

  // a taken request keeps the block busy until its result
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 busy ##1 (done && !busy))
    else $error("request did not complete in three cycles");

  a_no_idle_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a pending request");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (spans_valid == (stored_count >= ssg_pkg::COUNT_W'(2))))
    else $error("spans_valid disagrees with stored_count");

  a_zero_spans: assert property (@(posedge clk) disable iff (rst)
    done && !spans_valid |-> (shortest_span == '0) && (longest_span == '0))
    else $error("spans not zero while invalid");

  a_short_le_long: assert property (@(posedge clk) disable iff (rst)
    done && spans_valid |-> shortest_span <= longest_span)
    else $error("shortest span exceeds longest span");

endmodule

bind sorted_store_min_max_gap ssg_checker u_ssg_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .stored_count  (stored_count),
  .spans_valid   (spans_valid),
  .shortest_span (shortest_span),
  .longest_span  (longest_span)
);
